// File: rtl/core/dq_pkg.sv
package dq_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OCC_W  = 5;

	typedef enum logic [1:0] {
		OP_PUSH_BACK  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic [1:0] opcode;
		word_t      value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		word_t            popped_value;
		word_t            front_value;
		word_t            back_value;
		logic             is_empty;
		logic             is_full;
		logic [OCC_W-1:0] occupancy;
	} res_t;

	// shift controls broadcast to every cell, already gated by the empty/full checks
	typedef struct packed {
		logic push_back;
		logic push_front;
		logic pop_front;
		logic pop_back;
	} cell_ctrl_t;

endpackage

// File: rtl/core/dq_cell.sv
module dq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dq_pkg::cell_ctrl_t ctrl,
	input  dq_pkg::word_t      value,
	input  dq_pkg::word_t      left_data,
	input  logic               left_occ,
	input  dq_pkg::word_t      right_data,
	input  logic               right_occ,
	output dq_pkg::word_t      data,
	output logic               occ
);
	import dq_pkg::*;

	word_t data_q;
	logic  occ_q;
	word_t data_d;
	logic  occ_d;

	always_comb begin
		data_d = data_q;
		priority if (ctrl.push_front) begin
			data_d = left_data;
		end else if (ctrl.pop_front) begin
			data_d = right_data;
		end else if (ctrl.push_back && !occ_q && left_occ) begin
			data_d = value;
		end else begin
			data_d = data_q;
		end
	end

	always_comb begin
		occ_d = occ_q;
		priority if (ctrl.push_back || ctrl.push_front) begin
			occ_d = left_occ;
		end else if (ctrl.pop_front || ctrl.pop_back) begin
			occ_d = right_occ;
		end else begin
			occ_d = occ_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign occ  = occ_q;

endmodule

// File: rtl/core/dq_pick.sv
module dq_pick #(
	parameter int unsigned DEPTH = 16
) (
	input  logic [DEPTH-1:0][dq_pkg::WORD_W-1:0] data,
	input  logic [DEPTH-1:0]                     occ,
	output dq_pkg::word_t                        back,
	output dq_pkg::word_t                        before_back
);
	import dq_pkg::*;

	logic [DEPTH:0]       occ_ext;
	logic [DEPTH-1:0]     is_back;
	logic [WORD_W-1:0]    back_acc;
	logic [WORD_W-1:0]    prev_acc;

	assign occ_ext = {1'b0, occ};

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			is_back[i] = occ_ext[i] & ~occ_ext[i+1];
		end
	end

	// the occupied cells form a thermometer, so at most one cell is the back (none when empty)
	always_comb begin
		back_acc = '0;
		prev_acc = '0;
		for (int i = 0; i < DEPTH; i++) begin
			back_acc = back_acc | (data[i] & {WORD_W{is_back[i]}});
		end
		for (int i = 0; i < DEPTH - 1; i++) begin
			prev_acc = prev_acc | (data[i] & {WORD_W{is_back[i+1]}});
		end
	end

	assign back        = word_t'(back_acc);
	assign before_back = word_t'(prev_acc);

endmodule

// File: rtl/core/double_ended_queue_top.sv
// channel | valid     | stall     | payload
// --------+-----------+-----------+-----------------------
// request | cmd_valid | cmd_stall | cmd (dq_pkg::cmd_t)
// result  | res_valid | res_stall | res (dq_pkg::res_t)
//
// one request per cycle unless stalled, its result from the result register
// the row of cells shifts in a single step for every accepted push or pop
// a request is held off only while an untaken result sits in the register
// reset empties the queue; cell data needs no reset

module double_ended_queue_top #(
	parameter int unsigned DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  dq_pkg::cmd_t  cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output dq_pkg::res_t  res
);
	import dq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_d;
	logic                         res_valid_q;
	res_t                         res_q;
	res_t                         res_d;
	logic                         take;
	cell_ctrl_t                   ctrl;
	logic [DEPTH-1:0][WORD_W-1:0] cell_data;
	logic [DEPTH-1:0]             cell_occ;
	word_t                        back_cur;
	word_t                        before_back;
	word_t                        first_cur;
	word_t                        second_cur;
	logic                         empty_now;
	logic                         full_now;
	logic                         many_now;
	logic                         is_push;
	logic                         op_ok;

	assign cmd_stall = res_valid_q & res_stall;
	assign take      = cmd_valid & ~cmd_stall;

	assign empty_now = (count_q == '0);
	assign full_now  = (count_q == CW'(DEPTH));
	assign many_now  = (count_q >= CW'(2));
	assign is_push   = (cmd.opcode == OP_PUSH_BACK) || (cmd.opcode == OP_PUSH_FRONT);
	assign op_ok     = is_push ? ~full_now : ~empty_now;

	assign first_cur  = word_t'(cell_data[0]);
	assign second_cur = word_t'(cell_data[1]);

	always_comb begin
		ctrl            = '0;
		ctrl.push_back  = take && op_ok && (cmd.opcode == OP_PUSH_BACK);
		ctrl.push_front = take && op_ok && (cmd.opcode == OP_PUSH_FRONT);
		ctrl.pop_front  = take && op_ok && (cmd.opcode == OP_POP_FRONT);
		ctrl.pop_back   = take && op_ok && (cmd.opcode == OP_POP_BACK);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_data;
		logic  left_occ;
		word_t right_data;
		logic  right_occ;

		if (i == 0) begin : g_first
			assign left_data = cmd.value;
			assign left_occ  = 1'b1;
		end else begin : g_mid_l
			assign left_data = word_t'(cell_data[i-1]);
			assign left_occ  = cell_occ[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_data = '0;
			assign right_occ  = 1'b0;
		end else begin : g_mid_r
			assign right_data = word_t'(cell_data[i+1]);
			assign right_occ  = cell_occ[i+1];
		end

		word_t data_o;

		dq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.value      (cmd.value),
			.left_data  (left_data),
			.left_occ   (left_occ),
			.right_data (right_data),
			.right_occ  (right_occ),
			.data       (data_o),
			.occ        (cell_occ[i])
		);

		assign cell_data[i] = data_o;
	end

	dq_pick #(
		.DEPTH (DEPTH)
	) u_pick (
		.data        (cell_data),
		.occ         (cell_occ),
		.back        (back_cur),
		.before_back (before_back)
	);

	always_comb begin
		count_d            = count_q;
		res_d              = '0;
		res_d.status       = ST_OK;
		res_d.popped_value = '0;
		res_d.front_value  = empty_now ? word_t'(0) : first_cur;
		res_d.back_value   = empty_now ? word_t'(0) : back_cur;
		unique case (cmd.opcode)
			OP_PUSH_BACK: begin
				if (full_now) begin
					res_d.status = ST_FULL;
				end else begin
					count_d           = count_q + CW'(1);
					res_d.front_value = empty_now ? cmd.value : first_cur;
					res_d.back_value  = cmd.value;
				end
			end
			OP_PUSH_FRONT: begin
				if (full_now) begin
					res_d.status = ST_FULL;
				end else begin
					count_d           = count_q + CW'(1);
					res_d.front_value = cmd.value;
					res_d.back_value  = empty_now ? cmd.value : back_cur;
				end
			end
			OP_POP_FRONT: begin
				if (empty_now) begin
					res_d.status = ST_EMPTY;
				end else begin
					count_d            = count_q - CW'(1);
					res_d.popped_value = first_cur;
					res_d.front_value  = many_now ? second_cur : word_t'(0);
					res_d.back_value   = many_now ? back_cur : word_t'(0);
				end
			end
			OP_POP_BACK: begin
				if (empty_now) begin
					res_d.status = ST_EMPTY;
				end else begin
					count_d            = count_q - CW'(1);
					res_d.popped_value = back_cur;
					res_d.front_value  = many_now ? first_cur : word_t'(0);
					res_d.back_value   = many_now ? before_back : word_t'(0);
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
		res_d.is_empty  = (count_d == '0);
		res_d.is_full   = (count_d == CW'(DEPTH));
		res_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dq_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned RANDOM_ITEMS = 2000;
	localparam int unsigned CALM_ITEMS = 200;
	localparam int unsigned STUCK_LIMIT = 1000;
	localparam word_t WORD_MIN = 32'sh8000_0000;
	localparam word_t WORD_MAX = 32'sh7fff_ffff;

	class deque_mirror;
		word_t       slots [DEPTH];
		int unsigned head;
		int unsigned count;
		res_t        awaited [$];
		int unsigned failures;

		function new();
			head = 0;
			count = 0;
			failures = 0;
		endfunction

		function void note_request(cmd_t c);
			res_t    r;
			opcode_t op;
			op = opcode_t'(c.opcode);
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_PUSH_BACK, OP_PUSH_FRONT: begin
					if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else if (op == OP_PUSH_BACK) begin
						slots[(head + count) % DEPTH] = c.value;
						count++;
					end else begin
						head = (head + DEPTH - 1) % DEPTH;
						slots[head] = c.value;
						count++;
					end
				end
				default: begin
					if (count == 0) begin
						r.status = ST_EMPTY;
					end else if (op == OP_POP_FRONT) begin
						r.popped_value = slots[head];
						head = (head + 1) % DEPTH;
						count--;
					end else begin
						r.popped_value = slots[(head + count - 1) % DEPTH];
						count--;
					end
				end
			endcase
			if (count != 0) begin
				r.front_value = slots[head];
				r.back_value = slots[(head + count - 1) % DEPTH];
			end
			r.is_empty = (count == 0);
			r.is_full = (count == DEPTH);
			r.occupancy = OCC_W'(count);
			awaited.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				$error("result with no request pending");
				failures++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
			if (got.popped_value !== want.popped_value) begin
				$error("popped_value: expected %0d, got %0d", want.popped_value,
					got.popped_value);
				failures++;
			end
			if (got.front_value !== want.front_value) begin
				$error("front_value: expected %0d, got %0d", want.front_value,
					got.front_value);
				failures++;
			end
			if (got.back_value !== want.back_value) begin
				$error("back_value: expected %0d, got %0d", want.back_value,
					got.back_value);
				failures++;
			end
			if (got.is_empty !== want.is_empty) begin
				$error("is_empty: expected %0d, got %0d", want.is_empty, got.is_empty);
				failures++;
			end
			if (got.is_full !== want.is_full) begin
				$error("is_full: expected %0d, got %0d", want.is_full, got.is_full);
				failures++;
			end
			if (got.occupancy !== want.occupancy) begin
				$error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
				failures++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	int unsigned tx_gap_pct;
	int unsigned rx_stall_pct;
	int unsigned stuck_cycles;

	deque_mirror deque = new();

	double_ended_queue_top #(
		.DEPTH(DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			deque.check_result(res);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// result side stall bursts
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			res_stall <= 1'b0;
		end
	end

	task automatic send_request(input opcode_t op, input word_t v);
		cmd_t c;
		c.opcode = op;
		c.value = v;
		@(negedge clk);
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (cmd_stall);
		deque.note_request(c);
	endtask

	function automatic word_t pick_word();
		case ($urandom_range(0, 7))
			0: return WORD_MIN;
			1: return WORD_MAX;
			2: return '0;
			3: return -1;
			default: return word_t'($urandom);
		endcase
	endfunction

	task automatic run_directed();
		word_t edge_words [4];
		edge_words = '{WORD_MIN, WORD_MAX, 32'sh0, -32'sh1};
		// pops on an empty queue
		send_request(OP_POP_FRONT, WORD_MAX);
		send_request(OP_POP_BACK, -1);
		// push front into an empty queue
		send_request(OP_PUSH_FRONT, WORD_MIN);
		send_request(OP_POP_BACK, '0);
		// fill from both ends, then overflow, then pop from both ends
		for (int i = 0; i < DEPTH; i++) begin
			send_request((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
				(i < 4) ? edge_words[i] : word_t'($urandom));
		end
		send_request(OP_PUSH_BACK, 32'sh5555_5555);
		send_request(OP_PUSH_FRONT, 32'shaaaa_aaaa);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_BACK, '0);
	endtask

	task automatic run_random();
		int unsigned push_pct;
		int unsigned seg_left;
		opcode_t     op;
		push_pct = 50;
		seg_left = 0;
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(20, 80);
				push_pct = $urandom_range(0, 4) * 20 + 10;
				if (n < RANDOM_ITEMS - CALM_ITEMS) begin
					tx_gap_pct = $urandom_range(0, 3) * 8;
					rx_stall_pct = $urandom_range(0, 3) * 8;
				end else begin
					tx_gap_pct = 0;
					rx_stall_pct = 0;
				end
			end
			seg_left--;
			if ($urandom_range(0, 19) == 0) begin
				op = opcode_t'($urandom_range(0, 3));
			end else if ($urandom_range(0, 99) < push_pct) begin
				op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			end else begin
				op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
			end
			send_request(op, pick_word());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		tx_gap_pct = 20;
		rx_stall_pct = 20;
		run_directed();
		run_random();
		@(negedge clk);
		cmd_valid <= 1'b0;

		while (deque.awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (deque.failures == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
